// ----- hdl/pvb_pkg.sv -----
// ----------------------------------------------------------------------------
// pvb_pkg
// Shared constants for the vibrance pipeline: luma weights, fixed-point
// fraction widths and default sizes.
// ----------------------------------------------------------------------------
package pvb_pkg;

    // Default component width (unsigned Q0.B)
    localparam int COMPONENT_BITS_DEF = 16;

    // Luma weights, Q0.16, sum is exactly 1.0
    localparam int LUMA_FRAC = 16;
    localparam logic [LUMA_FRAC-1:0] LUMA_WEIGHT [3] = '{16'd13933, 16'd46871, 16'd4732};

    // Vibrance amount register, signed Q2.14
    localparam int AMOUNT_W    = 16;
    localparam int AMOUNT_FRAC = 14;

    // Queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Register stages in the back pipeline, output register included
    localparam int BACK_STAGES = 9;

    // Channel lanes
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int NUM_CH   = 3;

endpackage

// ----- hdl/pixel_vibrance_boost.sv -----
// Path: a pixel reaches m_tvalid through the front register, the queue and the
//   9-stage pipeline, whose last stage is the output register.
// Throughput: one pixel per clock while m_tready does not stall the output; every
//   stage is fully pipelined, the widest step being one difference-by-scale multiply per channel.
// Reset: synchronous active-low i_rst_n empties all stages and the queue and
//   clears the vibrance amount to zero (pixels pass through unchanged).
// ----------------------------------------------------------------------------
// pixel_vibrance_boost
// Vibrance adjustment with BT.709 luma on a pixel stream: a front stage
// takes and tags pixels, a short queue decouples it from the arithmetic
// pipeline, which drives a registered stream output.
// ----------------------------------------------------------------------------
module pixel_vibrance_boost import pvb_pkg::*; #(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
    parameter int TDATA_W        = ((4 * COMPONENT_BITS + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration: vibrance amount, signed Q2.14
    input  logic                i_amount_we,
    input  logic [AMOUNT_W-1:0] i_amount_wdata,
    // Pixel input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,   // red_in, green_in, blue_in, alpha_in, zero pad
    input  logic                s_tlast,   // last_in
    // Pixel output stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // red_out, green_out, blue_out, alpha_out, zero pad
    output logic                m_tlast    // last_out
);

    localparam int IW   = 4 * COMPONENT_BITS + 2;
    // Pixels the block can hold at once: front, queue, pipeline
    localparam int CAP  = 1 + QUEUE_DEPTH + BACK_STAGES;
    localparam int FW   = $clog2(CAP + 1);

    logic [AMOUNT_W-1:0]         r_amount;
    logic                        w_f_valid;
    logic                        w_q_full;
    logic [IW-1:0]               w_f_item;
    logic                        w_q_valid;
    logic                        w_q_pop;
    logic [IW-1:0]               w_q_item;
    logic [4*COMPONENT_BITS-1:0] w_out_data;
    logic [FW-1:0]               r_inflight;
    logic                        w_in_xact;
    logic                        w_out_xact;

    // Amount register: the user must write it only while the stream is idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amount <= '0;
        end else if (i_amount_we) begin
            r_amount <= i_amount_wdata;
        end
    end

    // Front: accept transactions, tag bypass when amount is zero
    pvb_front #(
        .COMP_BITS (COMPONENT_BITS),
        .TDATA_W   (TDATA_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_amount (r_amount),
        .i_tvalid (s_tvalid),
        .o_tready (s_tready),
        .i_tdata  (s_tdata),
        .i_tlast  (s_tlast),
        .o_valid  (w_f_valid),
        .i_ready  (!w_q_full),
        .o_item   (w_f_item)
    );

    // Queue: lets front and pipeline stall independently
    pvb_fifo #(
        .WIDTH (IW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_data  (w_f_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_item)
    );

    // Back: arithmetic pipeline with output register
    pvb_back #(
        .COMP_BITS (COMPONENT_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_amount (r_amount),
        .i_valid  (w_q_valid),
        .o_pop    (w_q_pop),
        .i_item   (w_q_item),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_data   (w_out_data),
        .o_last   (m_tlast)
    );

    // Zero-pad the packed components up to whole bytes
    assign m_tdata = TDATA_W'(w_out_data);

    // Track pixels held in the block
    assign w_in_xact  = s_tvalid && s_tready;
    assign w_out_xact = m_tvalid && m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            case ({w_in_xact, w_out_xact})
                2'b10:   r_inflight <= r_inflight + 1'b1;
                2'b01:   r_inflight <= r_inflight - 1'b1;
                default: r_inflight <= r_inflight;
            endcase
        end
    end

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= FW'(CAP))
        else $error("pixel_vibrance_boost: more pixels held than storage allows");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == '0) |-> !m_tvalid)
        else $error("pixel_vibrance_boost: output valid with no pixel inside");

    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == '0) |-> s_tready)
        else $error("pixel_vibrance_boost: empty block refuses input");

endmodule

// ----- hdl/pvb_front.sv -----
// ----------------------------------------------------------------------------
// pvb_front
// Input register stage: takes stream transactions, tags each pixel with a
// bypass flag (amount is zero) and hands it to the queue.
// ----------------------------------------------------------------------------
module pvb_front import pvb_pkg::*; #(
    parameter int COMP_BITS = COMPONENT_BITS_DEF,
    parameter int TDATA_W   = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [AMOUNT_W-1:0]    i_amount,
    input  logic                   i_tvalid,
    output logic                   o_tready,
    input  logic [TDATA_W-1:0]     i_tdata,   // red, green, blue, alpha
    input  logic                   i_tlast,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [4*COMP_BITS+1:0] o_item     // red, green, blue, alpha, last, bypass
);

    localparam int IW = 4 * COMP_BITS + 2;

    logic          r_vld;
    logic [IW-1:0] r_item;
    logic          w_take;

    // Free slot when empty or the queue takes the held pixel this cycle
    assign o_tready = !r_vld || i_ready;
    assign w_take   = i_tvalid && o_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_tready) begin
            r_vld <= i_tvalid;
        end
        if (w_take) begin
            r_item <= {(i_amount == '0), i_tlast, i_tdata[4*COMP_BITS-1:0]};
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

// ----- hdl/pvb_fifo.sv -----
// ----------------------------------------------------------------------------
// pvb_fifo
// Short first-in first-out queue decoupling the front stage from the
// arithmetic pipeline.
// ----------------------------------------------------------------------------
module pvb_fifo import pvb_pkg::*; #(
    parameter int WIDTH = 66,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push_ok;
    logic             w_pop_ok;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && o_valid;
    assign o_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push_ok) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push_ok, w_pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (w_push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("pvb_fifo: occupancy beyond depth");

    a_empty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && !i_push) |=> !o_valid)
        else $error("pvb_fifo: entry appeared without a push");

endmodule

// ----- hdl/pvb_back.sv -----
// ----------------------------------------------------------------------------
// pvb_back
// Arithmetic pipeline: luma, differences, squared chroma, mask, scale and
// per-channel saturating output or bypass. All stages advance together.
// ----------------------------------------------------------------------------
module pvb_back import pvb_pkg::*; #(
    parameter int COMP_BITS = COMPONENT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [AMOUNT_W-1:0]    i_amount,
    input  logic                   i_valid,
    output logic                   o_pop,
    input  logic [4*COMP_BITS+1:0] i_item,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [4*COMP_BITS-1:0] o_data,  // red, green, blue, alpha
    output logic                   o_last
);

    localparam int B    = COMP_BITS;
    localparam int NST  = BACK_STAGES;
    localparam int PW   = B + LUMA_FRAC;        // luma product
    localparam int LSW  = PW + 2;               // luma sum
    localparam int DW   = B + 1;                // signed difference
    localparam int QW   = 2 * B;                // square
    localparam int S4W  = 2 * B + 4;            // 4 * sum of squares
    localparam int MW   = B + 1;                // mask, 0 .. 1.0
    localparam int AMW  = AMOUNT_W + MW + 1;    // amount * mask
    localparam int SW   = B + 4;                // scale
    localparam int PDW  = DW + SW;              // d * scale

    // Stage valids and carried fields
    logic [NST-1:0]           r_vld;
    logic [B-1:0]             r_comp  [NST-1][NUM_CH];
    logic [B-1:0]             r_alpha [NST];
    logic                     r_last  [NST];
    logic                     r_byp   [NST];
    logic [B-1:0]             r_lum   [1:NST-2];
    logic signed [DW-1:0]     r_d     [2:NST-3][NUM_CH];

    // Stage-specific results
    logic [PW-1:0]            r_prod  [NUM_CH];
    logic [QW-1:0]            r_sq    [NUM_CH];
    logic [MW-1:0]            r_mask;
    logic signed [AMW-1:0]    r_amp;
    logic signed [SW-1:0]     r_scale;
    logic signed [PDW-1:0]    r_pd    [NUM_CH];
    logic [B-1:0]             r_out   [NUM_CH];

    logic                     w_adv;
    logic [B-1:0]             w_in_comp [NUM_CH];
    logic [LSW-1:0]           w_lum_sum;
    logic signed [2*DW-1:0]   w_sq_full [NUM_CH];
    logic [S4W-1:0]           w_sum4;
    logic [QW:0]              w_c2_sum;
    logic [MW-1:0]            w_mask;
    logic signed [AMW-1:0]    w_amp;
    logic signed [AMW-1:0]    w_sc_sum;
    logic signed [AMW-1:0]    w_sc_sh;
    logic signed [SW-1:0]     w_scale;
    logic signed [PDW-1:0]    w_pd      [NUM_CH];
    logic signed [PDW-1:0]    w_rnd     [NUM_CH];
    logic signed [PDW-1:0]    w_shr     [NUM_CH];
    logic signed [PDW:0]      w_v       [NUM_CH];
    logic [B-1:0]             w_sat     [NUM_CH];

    // Advance the whole pipe when the output register is free or drained
    assign w_adv = !r_vld[NST-1] || i_ready;
    assign o_pop = w_adv;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_in_comp[c] = i_item[c*B +: B];
        end

        w_lum_sum = LSW'(r_prod[CH_RED]) + LSW'(r_prod[CH_GREEN]) + LSW'(r_prod[CH_BLUE])
                  + (LSW'(1) << (LUMA_FRAC - 1));

        for (int c = 0; c < NUM_CH; c++) begin
            w_sq_full[c] = r_d[2][c] * r_d[2][c];
        end

        // Squared chroma, saturates at 1.0 so the mask bottoms out at zero
        w_sum4   = (S4W'(r_sq[CH_RED]) + S4W'(r_sq[CH_GREEN]) + S4W'(r_sq[CH_BLUE])) << 2;
        w_c2_sum = {1'b0, w_sum4[QW-1:0]} + ((QW+1)'(1) << (B - 1));
        if (|w_sum4[S4W-1:QW]) begin
            w_mask = '0;
        end else begin
            w_mask = (MW'(1) << B) - w_c2_sum[QW:B];
        end

        w_amp    = $signed(i_amount) * $signed({1'b0, r_mask});
        w_sc_sum = r_amp + (AMW'(1) << (AMOUNT_FRAC - 1));
        w_sc_sh  = w_sc_sum >>> AMOUNT_FRAC;
        w_scale  = SW'(w_sc_sh) + (SW'(1) << B);

        for (int c = 0; c < NUM_CH; c++) begin
            w_pd[c]  = r_d[NST-3][c] * r_scale;
            w_rnd[c] = r_pd[c] + (PDW'(1) << (B - 1));
            w_shr[c] = w_rnd[c] >>> B;
            w_v[c]   = $signed({w_shr[c][PDW-1], w_shr[c]})
                     + $signed({{(PDW + 1 - B){1'b0}}, r_lum[NST-2]});
            if (w_v[c][PDW]) begin
                w_sat[c] = '0;
            end else if (|w_v[c][PDW-1:B]) begin
                w_sat[c] = '1;
            end else begin
                w_sat[c] = w_v[c][B-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end

        if (w_adv) begin
            // Stage 0: capture from queue, luma products
            for (int c = 0; c < NUM_CH; c++) begin
                r_comp[0][c] <= w_in_comp[c];
                r_prod[c]    <= {{LUMA_FRAC{1'b0}}, w_in_comp[c]}
                              * {{B{1'b0}}, LUMA_WEIGHT[c]};
            end
            r_alpha[0] <= i_item[3*B +: B];
            r_last[0]  <= i_item[4*B];
            r_byp[0]   <= i_item[4*B+1];

            for (int k = 1; k < NST; k++) begin
                r_alpha[k] <= r_alpha[k-1];
                r_last[k]  <= r_last[k-1];
                r_byp[k]   <= r_byp[k-1];
            end
            for (int k = 1; k < NST - 1; k++) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_comp[k][c] <= r_comp[k-1][c];
                end
            end

            // Stage 1: luma
            r_lum[1] <= w_lum_sum[LUMA_FRAC +: B];
            for (int k = 2; k <= NST - 2; k++) begin
                r_lum[k] <= r_lum[k-1];
            end

            // Stage 2: differences from gray
            for (int c = 0; c < NUM_CH; c++) begin
                r_d[2][c] <= $signed({1'b0, r_comp[1][c]}) - $signed({1'b0, r_lum[1]});
                for (int k = 3; k <= NST - 3; k++) begin
                    r_d[k][c] <= r_d[k-1][c];
                end
            end

            // Stage 3: squares
            for (int c = 0; c < NUM_CH; c++) begin
                r_sq[c] <= w_sq_full[c][QW-1:0];
            end

            // Stage 4..6: mask, amount * mask, scale
            r_mask  <= w_mask;
            r_amp   <= w_amp;
            r_scale <= w_scale;

            // Stage 7: d * scale
            for (int c = 0; c < NUM_CH; c++) begin
                r_pd[c] <= w_pd[c];
            end

            // Stage 8: output register, bypass restores the pixel as given
            for (int c = 0; c < NUM_CH; c++) begin
                r_out[c] <= r_byp[NST-2] ? r_comp[NST-2][c] : w_sat[c];
            end
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_data  = {r_alpha[NST-1], r_out[CH_BLUE], r_out[CH_GREEN], r_out[CH_RED]};
    assign o_last  = r_last[NST-1];

endmodule

// ----- tb/sv/pixel_vibrance_boost_tb.sv -----
// ----------------------------------------------------------------------------
// pixel_vibrance_boost_tb
// Self-checking bench for the vibrance pipeline. A short directed pass walks
// gray, black, white and fully saturated pixels under zero, extreme and smallest
// nonzero vibrance amounts, then random pixel bursts (half near gray, where the chroma
// mask matters) run under several amount settings. Every output transaction is
// compared field by field with a typed result or a bit-exact fixed-point prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_vibrance_boost_tb;
    import pvb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB             = COMPONENT_BITS_DEF;
    localparam int TDW            = ((4 * CB + 7) / 8) * 8;
    localparam int DIR_ROWS       = 20;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 216;
    localparam int TAIL_CYCLES    = 16;   // a bit more than the pipeline latency
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [CB-1:0] FULL = '1;

    typedef struct packed {
        logic          last;
        logic [CB-1:0] alpha;
        logic [CB-1:0] blue;
        logic [CB-1:0] green;
        logic [CB-1:0] red;
    } pixel_t;

    // One directed row: amount to run under, the pixel, and optionally the
    // hand-derived color result (alpha and last always follow the input).
    typedef struct {
        int            amt;
        logic [CB-1:0] r, g, b, a;
        logic          last;
        bit            typed;
        logic [CB-1:0] er, eg, eb;
    } dir_row_t;

    // ---- DUT signals, inputs known from time zero ----
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_amount_we = 1'b0;
    logic [AMOUNT_W-1:0] i_amount_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDW-1:0]      s_tdata = '0;     // red_in, green_in, blue_in, alpha_in
    logic                s_tlast = 1'b0;   // last_in
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDW-1:0]      m_tdata;          // red_out, green_out, blue_out, alpha_out
    logic                m_tlast;          // last_out

    // ---- bench state ----
    logic signed [AMOUNT_W-1:0] vib_amount = '0;   // mirror of the amount register
    pixel_t   boosted_q [$];                        // predicted pixels, oldest first
    dir_row_t dir_tab [DIR_ROWS];
    int       err_cnt = 0;
    int       pixels_sent = 0;
    int       pixels_checked = 0;
    int       last_marks = 0;
    int       amount_writes = 0;
    int       idle_cycles = 0;
    int       rdy_mode = 0;
    int       rdy_left = 0;
    int       rdy_tick = 0;

    pixel_vibrance_boost dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_amount_we   (i_amount_we),
        .i_amount_wdata(i_amount_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Fixed-point prediction
    // ------------------------------------------------------------------------

    // Round to nearest, halves toward plus infinity: floor((x + 2^(k-1)) / 2^k).
    // longint is signed, so >>> floors negative values as needed.
    function automatic longint round_q(input longint x, input int k);
        return (x + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic logic [CB-1:0] clamp_comp(input longint v);
        if (v < 0)
            return '0;
        if (v > longint'(FULL))
            return FULL;
        return v[CB-1:0];
    endfunction

    function automatic pixel_t boost_pixel(input pixel_t px,
                                           input logic signed [AMOUNT_W-1:0] amt);
        longint one;
        longint lum, dr, dg, db, sum4, c2, chroma_mask, scl;
        pixel_t res;
        one = longint'(1) << CB;
        res = px;
        // Zero amount bypasses the arithmetic entirely
        if (amt == 0)
            return res;
        lum = round_q(longint'(px.red)   * longint'(LUMA_WEIGHT[CH_RED])
                    + longint'(px.green) * longint'(LUMA_WEIGHT[CH_GREEN])
                    + longint'(px.blue)  * longint'(LUMA_WEIGHT[CH_BLUE]), LUMA_FRAC);
        dr = longint'(px.red)   - lum;
        dg = longint'(px.green) - lum;
        db = longint'(px.blue)  - lum;
        // Squared chroma normalized to a 0.5 maximum, clamped to 1.0
        sum4 = 4 * (dr * dr + dg * dg + db * db);
        if (sum4 >= one * one) begin
            c2 = one;
        end else begin
            c2 = round_q(sum4, CB);
            if (c2 > one)
                c2 = one;
        end
        chroma_mask = one - c2;
        scl = one + round_q(longint'(amt) * chroma_mask, AMOUNT_FRAC);
        res.red   = clamp_comp(lum + round_q(dr * scl, CB));
        res.green = clamp_comp(lum + round_q(dg * scl, CB));
        res.blue  = clamp_comp(lum + round_q(db * scl, CB));
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [CB-1:0] pick_extreme();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return FULL;
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic logic [CB-1:0] near_value(input int base, input int spread);
        int v;
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > int'(FULL))
            v = int'(FULL);
        return CB'(v);
    endfunction

    // Half near-gray pixels with a random spread, so the chroma mask takes
    // values across its whole range; the rest are noise, extremes and grays.
    function automatic pixel_t rand_pixel();
        pixel_t px;
        int     kind, base, spread;
        kind   = $urandom_range(0, 9);
        base   = $urandom_range(0, int'(FULL));
        spread = 1 << $urandom_range(2, 14);
        px.alpha = CB'($urandom);
        px.last  = ($urandom_range(0, 15) == 0);
        if (kind <= 4) begin
            px.red   = near_value(base, spread);
            px.green = near_value(base, spread);
            px.blue  = near_value(base, spread);
        end else if (kind <= 7) begin
            px.red   = CB'($urandom);
            px.green = CB'($urandom);
            px.blue  = CB'($urandom);
        end else if (kind == 8) begin
            px.red   = pick_extreme();
            px.green = pick_extreme();
            px.blue  = pick_extreme();
        end else begin
            px.red   = CB'(base);
            px.green = CB'(base);
            px.blue  = CB'(base);
        end
        return px;
    endfunction

    // Present one pixel and hold it until the input transaction completes;
    // log the expected result at that point. Called right after i_clk rises.
    task automatic send_pixel(input pixel_t px, input bit typed, input pixel_t want);
        s_tvalid <= 1'b1;
        s_tdata  <= {px.alpha, px.blue, px.green, px.red};
        s_tlast  <= px.last;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        boosted_q.push_back(typed ? want : boost_pixel(px, vib_amount));
        pixels_sent++;
        if (px.last)
            last_marks++;
    endtask

    // Drop valid and hold until every logged result has come out. One result
    // per pixel, so an empty log means the pipeline is empty.
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (boosted_q.size() != 0);
    endtask

    task automatic write_amount(input int v);
        i_amount_we    <= 1'b1;
        i_amount_wdata <= v[AMOUNT_W-1:0];
        @(posedge i_clk);
        i_amount_we <= 1'b0;
        vib_amount = v[AMOUNT_W-1:0];
        amount_writes++;
    endtask

    task automatic check_field(input string name, input logic [CB-1:0] exp_v,
                               input logic [CB-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: check each output transaction, then pick the next ready.
    // The ready pattern switches at random between four modes: always ready,
    // sparse random stalls, a fixed one-in-four stall, and heavy random stalls.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (boosted_q.size() == 0) begin
                $display("%0t: unexpected output pixel %h, last %b", $realtime, m_tdata,
                         m_tlast);
                err_cnt++;
            end else begin
                check_field("red",   boosted_q[0].red,   m_tdata[0*CB +: CB]);
                check_field("green", boosted_q[0].green, m_tdata[1*CB +: CB]);
                check_field("blue",  boosted_q[0].blue,  m_tdata[2*CB +: CB]);
                check_field("alpha", boosted_q[0].alpha, m_tdata[3*CB +: CB]);
                check_field("last",  CB'(boosted_q[0].last), CB'(m_tlast));
                void'(boosted_q.pop_front());
                pixels_checked++;
            end
        end

        if (rdy_left == 0) begin
            rdy_mode <= $urandom_range(0, 3);
            rdy_left <= $urandom_range(64, 256);
        end else begin
            rdy_left <= rdy_left - 1;
        end
        rdy_tick <= rdy_tick + 1;
        case (rdy_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= (rdy_tick % 4 != 3);
            default: m_tready <= ($urandom_range(0, 2) == 0);
        endcase
    end

    // Watchdog: end the run when no transaction moves on either side for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $realtime,
                     boosted_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        pixel_t px;
        pixel_t want;
        int     amt;
        int     burst_left;
        int     gap;

        // Directed rows. Typed results: amount zero passes the pixel through;
        // a gray pixel has no color difference, so it comes out as its own
        // luma, i.e. unchanged; a fully saturated pixel has a zero mask, so the
        // scale is exactly one and it is unchanged too. Others use the predictor.
        dir_tab = '{
            // reset amount: bypass, including all-ones and alpha toggles
            '{0,      16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1,
              16'h0000, 16'h0000, 16'h0000},
            '{0,      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1,
              16'hFFFF, 16'hFFFF, 16'hFFFF},
            '{0,      16'h1234, 16'hABCD, 16'h8000, 16'h5555, 1'b0, 1,
              16'h1234, 16'hABCD, 16'h8000},
            '{0,      16'hFFFF, 16'h0000, 16'h0000, 16'hAAAA, 1'b0, 1,
              16'hFFFF, 16'h0000, 16'h0000},
            // largest positive amount
            '{32767,  16'h0000, 16'h0000, 16'h0000, 16'h0F0F, 1'b0, 1,
              16'h0000, 16'h0000, 16'h0000},
            '{32767,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hF0F0, 1'b0, 1,
              16'hFFFF, 16'hFFFF, 16'hFFFF},
            '{32767,  16'h8000, 16'h8000, 16'h8000, 16'h0001, 1'b1, 1,
              16'h8000, 16'h8000, 16'h8000},
            '{32767,  16'hFFFF, 16'h0000, 16'h0000, 16'h8000, 1'b0, 1,
              16'hFFFF, 16'h0000, 16'h0000},
            '{32767,  16'h0000, 16'h0000, 16'hFFFF, 16'h7FFF, 1'b0, 1,
              16'h0000, 16'h0000, 16'hFFFF},
            '{32767,  16'h8000, 16'h8400, 16'h7C00, 16'h1111, 1'b0, 0,
              16'h0000, 16'h0000, 16'h0000},
            '{32767,  16'hF000, 16'hFFFF, 16'hF000, 16'h2222, 1'b0, 0,
              16'h0000, 16'h0000, 16'h0000},
            '{32767,  16'h0800, 16'h0000, 16'h0400, 16'h3333, 1'b0, 0,
              16'h0000, 16'h0000, 16'h0000},
            // most negative amount: inverts low-chroma color about the luma
            '{-32768, 16'h4000, 16'h4000, 16'h4000, 16'h4444, 1'b0, 1,
              16'h4000, 16'h4000, 16'h4000},
            '{-32768, 16'h8000, 16'h8200, 16'h7E00, 16'h5555, 1'b0, 0,
              16'h0000, 16'h0000, 16'h0000},
            '{-32768, 16'h0000, 16'hFFFF, 16'h0000, 16'h6666, 1'b1, 1,
              16'h0000, 16'hFFFF, 16'h0000},
            '{-32768, 16'h1000, 16'h0000, 16'h0000, 16'h7777, 1'b0, 0,
              16'h0000, 16'h0000, 16'h0000},
            // smallest nonzero amounts
            '{1,      16'h8000, 16'h8100, 16'h7F00, 16'h8888, 1'b0, 0,
              16'h0000, 16'h0000, 16'h0000},
            '{1,      16'hFFFF, 16'hFFFF, 16'h0000, 16'h9999, 1'b0, 1,
              16'hFFFF, 16'hFFFF, 16'h0000},
            '{-1,     16'h3000, 16'h3100, 16'h2F00, 16'hCCCC, 1'b1, 0,
              16'h0000, 16'h0000, 16'h0000},
            '{-1,     16'hFFFE, 16'h0001, 16'h7FFF, 16'h0000, 1'b0, 0,
              16'h0000, 16'h0000, 16'h0000}
        };

        // Hold reset, then release it for good
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed pass ----
        for (int i = 0; i < DIR_ROWS; i++) begin
            // Change the amount only with the pipeline empty
            if (dir_tab[i].amt != int'(vib_amount)) begin
                drain_pipe();
                write_amount(dir_tab[i].amt);
            end
            px.red   = dir_tab[i].r;
            px.green = dir_tab[i].g;
            px.blue  = dir_tab[i].b;
            px.alpha = dir_tab[i].a;
            px.last  = dir_tab[i].last;
            want       = px;
            want.red   = dir_tab[i].er;
            want.green = dir_tab[i].eg;
            want.blue  = dir_tab[i].eb;
            send_pixel(px, dir_tab[i].typed, want);
            gap = $urandom_range(0, 2);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        // ---- random bursts under several amount settings ----
        burst_left = 0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       amt = 16384;     // +1.0
                1:       amt = -16384;    // -1.0
                2:       amt = 0;         // explicit bypass
                3:       amt = 32767;
                4:       amt = -32768;
                7:       amt = 8192;      // +0.5
                default: amt = int'($urandom_range(0, 65535)) - 32768;
            endcase
            drain_pipe();
            write_amount(amt);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_pixel(rand_pixel(), 1'b0, '0);
                // Once mid-stream, hold the sender until the output catches up
                if (p == 1 && n == 100)
                    drain_pipe();
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap != 0) begin
                        s_tvalid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
        end

        // ---- wind down: empty the pipeline, then watch for stray outputs ----
        drain_pipe();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (boosted_q.size() != 0) begin
            $display("%0t: %0d expected pixels never came out", $realtime, boosted_q.size());
            err_cnt++;
        end

        $display("Run: %0d pixels in, %0d checked, %0d end-of-image marks, %0d amount writes",
                 pixels_sent, pixels_checked, last_marks, amount_writes);
        $display("Amounts covered bypass, +/-1.0, both extremes, +/-1 LSB and random values");
        if (err_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
